@@ sv/edf_pkg.sv @@
`default_nettype none

package edf_pkg;

  localparam int NUM_TASKS   = 4;
  localparam int IDX_W       = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int CNT_W       = $clog2(NUM_TASKS + 1);

  localparam int TASK_IN_W   = 3;
  localparam int TIME_W      = 32;
  localparam int RANK_W      = 2;
  localparam int PRIO_W      = 3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MASK    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD0 = 8'd1;

  // input word layout
  localparam int IN_TASK_LSB  = 0;
  localparam int IN_PRIOR_LSB = IN_TASK_LSB + TASK_IN_W;
  localparam int IN_STEP_LSB  = IN_PRIOR_LSB + TIME_W;
  localparam int IN_NOW_LSB   = IN_STEP_LSB + TIME_W;
  localparam int IN_BITS      = IN_NOW_LSB + TIME_W;
  localparam int S_DATA_W     = ((IN_BITS + 7) / 8) * 8;

  // output word layout
  localparam int OUT_MISS_LSB = 0;
  localparam int OUT_WAKE_LSB = OUT_MISS_LSB + 1;
  localparam int OUT_RANK_LSB = OUT_WAKE_LSB + TIME_W;
  localparam int OUT_PRIO_LSB = OUT_RANK_LSB + RANK_W;
  localparam int OUT_BITS     = OUT_PRIO_LSB + PRIO_W;
  localparam int M_DATA_W     = ((OUT_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic              ok;
    logic [RANK_W-1:0] task_id;
    logic [TIME_W-1:0] wake;
    logic [TIME_W-1:0] now;
  } job_t;

  typedef struct packed {
    logic [RANK_W-1:0] task_id;
    logic [TIME_W-1:0] deadline;
  } slot_t;

  typedef struct packed {
    logic              accepted;
    logic              missed;
    logic [TIME_W-1:0] next_wake;
    logic [RANK_W-1:0] ranked_task;
    logic [PRIO_W-1:0] priority_res;
    logic              last;
  } result_t;

  // wrap-safe "a strictly after b"
  function automatic logic later_than(input logic [TIME_W-1:0] a,
                                      input logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] d;
    d = a - b;
    return (d != '0) && !d[TIME_W-1];
  endfunction

endpackage

`default_nettype wire

@@ sv/edf_front.sv @@
`default_nettype none

module edf_front (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          s_tvalid,
  output logic                         s_tready,
  input  wire [edf_pkg::S_DATA_W-1:0]  s_tdata,
  input  wire [edf_pkg::NUM_TASKS-1:0] mask,
  output logic                         job_valid,
  input  wire                          job_ready,
  output edf_pkg::job_t                job
);

  logic [edf_pkg::TASK_IN_W-1:0] ev_task;
  logic [edf_pkg::TIME_W-1:0]    prior_wake;
  logic [edf_pkg::TIME_W-1:0]    wake_step;
  logic [edf_pkg::TIME_W-1:0]    now_tick;
  logic [edf_pkg::IDX_W-1:0]     ev_idx;
  logic                          ev_ok;

  assign ev_task    = s_tdata[edf_pkg::IN_TASK_LSB +: edf_pkg::TASK_IN_W];
  assign prior_wake = s_tdata[edf_pkg::IN_PRIOR_LSB +: edf_pkg::TIME_W];
  assign wake_step  = s_tdata[edf_pkg::IN_STEP_LSB +: edf_pkg::TIME_W];
  assign now_tick   = s_tdata[edf_pkg::IN_NOW_LSB +: edf_pkg::TIME_W];
  assign ev_idx     = ev_task[edf_pkg::IDX_W-1:0];

  // out-of-range tasks and unregistered tasks are rejected
  assign ev_ok = (ev_task < edf_pkg::TASK_IN_W'(edf_pkg::NUM_TASKS)) && mask[ev_idx];

  assign s_tready = !job_valid || job_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      job_valid <= 1'b1;
    end else if (job_ready) begin
      job_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      job.ok      <= ev_ok;
      job.task_id <= edf_pkg::RANK_W'(ev_idx);
      job.wake    <= prior_wake + wake_step;
      job.now     <= now_tick;
    end
  end

endmodule

`default_nettype wire

@@ sv/edf_queue.sv @@
`default_nettype none

module edf_queue (
  input  wire            clk,
  input  wire            rst,
  input  wire            push_valid,
  output logic           push_ready,
  input  edf_pkg::job_t  push_data,
  output logic           pop_valid,
  input  wire            pop_ready,
  output edf_pkg::job_t  pop_data
);

  edf_pkg::job_t                 mem [edf_pkg::QUEUE_DEPTH];
  logic [edf_pkg::QPTR_W-1:0]    wr_ptr;
  logic [edf_pkg::QPTR_W-1:0]    rd_ptr;
  logic [edf_pkg::QCNT_W-1:0]    fill;
  logic                          do_push;
  logic                          do_pop;

  assign push_ready = (fill != edf_pkg::QCNT_W'(edf_pkg::QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ sv/edf_back.sv @@
`default_nettype none

module edf_back (
  input  wire                                             clk,
  input  wire                                             rst,
  input  wire                                             job_valid,
  output logic                                            job_ready,
  input  edf_pkg::job_t                                   job,
  input  wire [edf_pkg::NUM_TASKS-1:0]                    mask,
  input  wire [edf_pkg::NUM_TASKS-1:0][edf_pkg::TIME_W-1:0] periods,
  output logic                                            m_tvalid,
  input  wire                                             m_tready,
  output logic [edf_pkg::M_DATA_W-1:0]                    m_tdata,  // missed, next_wake,
                                                                    // ranked_task, priority_res
  output logic                                            m_tuser,  // accepted
  output logic                                            m_tlast
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_SORT = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]                   state;
  logic [edf_pkg::TIME_W-1:0]   dl_table [edf_pkg::NUM_TASKS];
  edf_pkg::slot_t               slot     [edf_pkg::NUM_TASKS];
  edf_pkg::slot_t               ld_slot  [edf_pkg::NUM_TASKS];
  logic [edf_pkg::CNT_W-1:0]    ld_cnt;
  logic [edf_pkg::CNT_W-1:0]    rem;
  logic [edf_pkg::IDX_W-1:0]    lim;
  logic [edf_pkg::IDX_W-1:0]    j;
  logic [edf_pkg::IDX_W-1:0]    jn;
  logic [edf_pkg::IDX_W-1:0]    job_idx;
  logic                         miss;
  logic [edf_pkg::TIME_W-1:0]   wake;
  edf_pkg::result_t             res;
  logic                         out_free;
  logic                         out_load;
  logic                         swap;
  edf_pkg::slot_t               cmp_a;
  edf_pkg::slot_t               cmp_b;

  assign out_free  = !m_tvalid || m_tready;
  assign job_idx   = job.task_id[edf_pkg::IDX_W-1:0];
  assign job_ready = (state == ST_IDLE) && (job.ok || out_free);

  // a new result word goes into the output register
  assign out_load  = ((state == ST_IDLE) && job_valid && job_ready && !job.ok) ||
                     ((state == ST_EMIT) && out_free);

  // registered tasks in ascending index order
  always_comb begin
    ld_cnt = '0;
    for (int i = 0; i < edf_pkg::NUM_TASKS; i++) begin
      ld_slot[i] = '0;
    end
    for (int i = 0; i < edf_pkg::NUM_TASKS; i++) begin
      if (mask[i]) begin
        ld_slot[ld_cnt[edf_pkg::IDX_W-1:0]].task_id  = edf_pkg::RANK_W'(i);
        ld_slot[ld_cnt[edf_pkg::IDX_W-1:0]].deadline = dl_table[i];
        ld_cnt = ld_cnt + 1'b1;
      end
    end
  end

  // one compare-swap of the bubble sort per cycle
  assign jn    = j + 1'b1;
  assign cmp_a = slot[j];
  assign cmp_b = slot[jn];
  assign swap  = edf_pkg::later_than(cmp_a.deadline, cmp_b.deadline);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      for (int i = 0; i < edf_pkg::NUM_TASKS; i++) begin
        dl_table[i] <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (job_valid && job_ready) begin
            if (!job.ok) begin
              res <= '{accepted: 1'b0, missed: 1'b0, next_wake: '0,
                       ranked_task: '0, priority_res: '0, last: 1'b1};
            end else begin
              dl_table[job_idx] <= job.wake + periods[job_idx];
              miss  <= edf_pkg::later_than(job.now, job.wake);
              wake  <= job.wake;
              state <= ST_LOAD;
            end
          end
        end
        ST_LOAD: begin
          for (int i = 0; i < edf_pkg::NUM_TASKS; i++) begin
            slot[i] <= ld_slot[i];
          end
          rem   <= ld_cnt;
          lim   <= edf_pkg::IDX_W'(ld_cnt - 1'b1);
          j     <= '0;
          state <= (ld_cnt > edf_pkg::CNT_W'(1)) ? ST_SORT : ST_EMIT;
        end
        ST_SORT: begin
          if (swap) begin
            slot[j]  <= cmp_b;
            slot[jn] <= cmp_a;
          end
          if (jn == lim) begin
            j   <= '0;
            lim <= lim - 1'b1;
            if (lim == edf_pkg::IDX_W'(1)) begin
              state <= ST_EMIT;
            end
          end else begin
            j <= jn;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            res.accepted     <= 1'b1;
            res.missed       <= miss;
            res.next_wake    <= wake;
            res.ranked_task  <= slot[0].task_id;
            res.priority_res <= edf_pkg::PRIO_W'(rem);
            res.last         <= (rem == edf_pkg::CNT_W'(1));
            for (int i = 0; i < edf_pkg::NUM_TASKS - 1; i++) begin
              slot[i] <= slot[i+1];
            end
            rem <= rem - 1'b1;
            if (rem == edf_pkg::CNT_W'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    m_tdata = '0;
    m_tdata[edf_pkg::OUT_MISS_LSB]                      = res.missed;
    m_tdata[edf_pkg::OUT_WAKE_LSB +: edf_pkg::TIME_W]   = res.next_wake;
    m_tdata[edf_pkg::OUT_RANK_LSB +: edf_pkg::RANK_W]   = res.ranked_task;
    m_tdata[edf_pkg::OUT_PRIO_LSB +: edf_pkg::PRIO_W]   = res.priority_res;
  end

  assign m_tuser = res.accepted;
  assign m_tlast = res.last;

endmodule

`default_nettype wire

@@ sv/edf_deadline_ranker_top.sv @@
// Earliest-deadline-first ranker. Each input word reports a finished job
// (event_task, prior_wake, wake_step, now_tick). A valid, registered task
// gets next_wake = prior_wake + wake_step, a miss flag when now_tick is past
// next_wake, and a new absolute deadline next_wake + period; then every
// registered task is sent out in deadline order (wrap-safe compare, ties to
// the lower index), one word per task, priorities from the task count down
// to 1, the final word marked by m_tlast. A rejected event yields a single
// all-zero word with m_tuser low and m_tlast high. A small queue sits between
// the input stage and the ranking engine, so new events are taken while
// results are still going out. With n registered tasks an accepted event
// occupies the engine for a load step, a bubble sort of n(n-1)/2
// compare-swaps on the single compare-swap unit, one pair per cycle, and
// n result words, one word per cycle while m_tready does not stall the
// output. Configuration: index 0 is the task mask, 1 to 4 the task periods;
// other indexes are ignored, and writes are expected only while idle.
`default_nettype none

module edf_deadline_ranker_top (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              s_tvalid,
  output logic                             s_tready,
  input  wire [edf_pkg::S_DATA_W-1:0]      s_tdata,   // event_task, prior_wake,
                                                      // wake_step, now_tick
  output logic                             m_tvalid,
  input  wire                              m_tready,
  output logic [edf_pkg::M_DATA_W-1:0]     m_tdata,   // missed, next_wake,
                                                      // ranked_task, priority_res
  output logic                             m_tuser,   // accepted
  output logic                             m_tlast,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire [edf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [edf_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [edf_pkg::NUM_TASKS-1:0]                      mask;
  logic [edf_pkg::NUM_TASKS-1:0][edf_pkg::TIME_W-1:0] periods;

  logic           fr_valid;
  logic           fr_ready;
  edf_pkg::job_t  fr_job;
  logic           q_valid;
  logic           q_ready;
  edf_pkg::job_t  q_job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask    <= '0;
      periods <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == edf_pkg::REG_MASK) begin
        mask <= cfg_data[edf_pkg::NUM_TASKS-1:0];
      end
      for (int i = 0; i < edf_pkg::NUM_TASKS; i++) begin
        if (cfg_index == edf_pkg::REG_PERIOD0 + edf_pkg::CFG_IDX_W'(i)) begin
          periods[i] <= cfg_data;
        end
      end
    end
  end

  edf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .mask      (mask),
    .job_valid (fr_valid),
    .job_ready (fr_ready),
    .job       (fr_job)
  );

  edf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_data  (fr_job),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_job)
  );

  edf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_valid),
    .job_ready (q_ready),
    .job       (q_job),
    .mask      (mask),
    .periods   (periods),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

`default_nettype wire

@@ sv/edf_checker.sv @@
`default_nettype none

module edf_checker (
  input wire                          clk,
  input wire                          rst,
  input wire                          m_tvalid,
  input wire                          m_tready,
  input wire [edf_pkg::M_DATA_W-1:0]  m_tdata,
  input wire                          m_tuser,
  input wire                          m_tlast
);

  logic [edf_pkg::PRIO_W-1:0] prio;

  assign prio = m_tdata[edf_pkg::OUT_PRIO_LSB +: edf_pkg::PRIO_W];

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("result word changed while stalled");

  // rejected events give one all-zero closing word
  a_reject_shape: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tlast && (m_tdata == '0))
    else $error("rejected result not a single zero word");

  // ranked words carry a nonzero priority and close at priority one
  a_last_prio: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (prio != '0) && (m_tlast == (prio == edf_pkg::PRIO_W'(1))))
    else $error("priority and last marker disagree");

  // no result survives reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

endmodule

bind edf_deadline_ranker_top edf_checker u_edf_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire
